@@ src/seg_clip_pkg.sv @@
// ----------------------------------------------------------------------------
// seg_clip_pkg
// Shared constants and register codes for the segment rectangle clipper.
// ----------------------------------------------------------------------------
package seg_clip_pkg;

  // clip parameter t is unsigned Q2.16
  localparam int T_FRAC    = 16;
  // quotient bits produced by the divider chain (t up to 2^18 - 1)
  localparam int T_BITS    = T_FRAC + 2;
  localparam int NUM_LANES = 4;
  localparam int NUM_STEPS = T_BITS;
  localparam int IDX_W     = 8;

  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(65536);
  localparam logic [T_BITS-1:0] T_SAT = T_BITS'(65537);

  typedef enum logic [IDX_W-1:0] {
    REG_LEFT   = 8'd0,
    REG_TOP    = 8'd1,
    REG_WIDTH  = 8'd2,
    REG_HEIGHT = 8'd3
  } reg_idx_t;

endpackage

@@ src/seg_clip_if.sv @@
// ----------------------------------------------------------------------------
// seg_clip interfaces
// Segment input, clip result and configuration write channels.
// ----------------------------------------------------------------------------
interface seg_clip_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface seg_clip_out_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic signed [COORD_BITS-1:0] clipped_start_x;
  logic signed [COORD_BITS-1:0] clipped_start_y;
  logic signed [COORD_BITS-1:0] clipped_end_x;
  logic signed [COORD_BITS-1:0] clipped_end_y;
  modport source (output valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink (input valid, visible, clipped_start_x, clipped_start_y,
                clipped_end_x, clipped_end_y, output ready);
endinterface

interface seg_clip_cfg_if #(parameter int COORD_BITS = 24);
  logic                              valid;
  logic                              ready;
  logic [seg_clip_pkg::IDX_W-1:0]    index;
  logic [COORD_BITS-1:0]             data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/segment_rect_clipper.sv @@
// ----------------------------------------------------------------------------
// segment_rect_clipper
// Liang-Barsky clipping of a segment against a configured rectangle.
// ----------------------------------------------------------------------------
// seg_in takes one segment word (start and end point, signed fixed point) per
// valid/ready handshake; seg_out returns one word per segment: a visible flag
// and the clipped endpoints, or the endpoints unchanged when rejected. cfg
// writes the rectangle registers (left, top, width, height) by index; it is
// always ready and writes to unknown indexes are dropped.
// From accept to result a segment passes one prep stage, 18 divider
// cells (one quotient bit of t per cell for every rectangle side at once),
// one edge fold stage, one multiply stage and the output register.
// Throughput is one segment per cycle while seg_out is not stalled; the rate
// is set by the divider chain, which then takes a new word every cycle.
// Each stage has its own valid bit and holds while full and its successor
// cannot take the word, so a stalled receiver backs up the chain and bubbles
// are squeezed out. Reset clears all valid bits and the rectangle registers.
// ----------------------------------------------------------------------------
module segment_rect_clipper #(
  parameter int COORD_BITS = 24
) (
  input logic                clk,
  input logic                rst,
  seg_clip_in_if.sink        seg_in,
  seg_clip_out_if.source     seg_out,
  seg_clip_cfg_if.sink       cfg
);

  localparam int CB  = COORD_BITS;
  localparam int QW  = CB + 2;
  localparam int TB  = seg_clip_pkg::T_BITS;
  localparam int NL  = seg_clip_pkg::NUM_LANES;
  localparam int NS  = seg_clip_pkg::NUM_STEPS;
  localparam int PW  = CB + 1 + TB;

  typedef struct packed {
    logic signed [CB-1:0] x0;
    logic signed [CB-1:0] y0;
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic [NL-1:0]        pz;
    logic [NL-1:0]        pneg;
    logic [NL-1:0]        qneg;
    logic [NL-1:0]        qz;
    logic [NL-1:0]        tneg;
    logic [NL-1:0]        ovf;
  } side_t;

  localparam int SW = $bits(side_t);

  // rectangle registers
  logic signed [CB-1:0] clip_left;
  logic signed [CB-1:0] clip_top;
  logic [CB-2:0]        clip_width;
  logic [CB-2:0]        clip_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= '0;
      clip_height <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        seg_clip_pkg::REG_LEFT:   clip_left   <= cfg.data;
        seg_clip_pkg::REG_TOP:    clip_top    <= cfg.data;
        seg_clip_pkg::REG_WIDTH:  clip_width  <= cfg.data[CB-2:0];
        seg_clip_pkg::REG_HEIGHT: clip_height <= cfg.data[CB-2:0];
        default: ;
      endcase
    end
  end

  // prep: edge distances, divisor magnitudes, first remainder
  side_t                     prep_side;
  logic [NL-1:0][CB:0]       prep_den;
  logic [NL-1:0][CB:0]       prep_rem;
  logic [NL-1:0][TB-1:0]     prep_lowq;

  always_comb begin
    logic signed [QW-1:0] q [NL];
    logic signed [CB:0]   p [NL];
    logic [QW-1:0]        n;
    prep_side.x0 = seg_in.start_x;
    prep_side.y0 = seg_in.start_y;
    prep_side.x1 = seg_in.end_x;
    prep_side.y1 = seg_in.end_y;
    prep_side.dx = (CB+1)'(seg_in.end_x) - (CB+1)'(seg_in.start_x);
    prep_side.dy = (CB+1)'(seg_in.end_y) - (CB+1)'(seg_in.start_y);
    p[0] = -prep_side.dx;
    p[1] = prep_side.dx;
    p[2] = -prep_side.dy;
    p[3] = prep_side.dy;
    q[0] = QW'(seg_in.start_x) - QW'(clip_left);
    q[1] = QW'(clip_left) + $signed(QW'(clip_width)) - QW'(seg_in.start_x);
    q[2] = QW'(seg_in.start_y) - QW'(clip_top);
    q[3] = QW'(clip_top) + $signed(QW'(clip_height)) - QW'(seg_in.start_y);
    for (int l = 0; l < NL; l++) begin
      prep_side.pz[l]   = p[l] == '0;
      prep_side.pneg[l] = p[l][CB];
      prep_side.qneg[l] = q[l][QW-1];
      prep_side.qz[l]   = q[l] == '0;
      prep_side.tneg[l] = (q[l] != '0) && (q[l][QW-1] != p[l][CB]);
      prep_den[l]       = p[l][CB] ? (CB+1)'(-p[l]) : (CB+1)'(p[l]);
      n                 = q[l][QW-1] ? QW'(-q[l]) : QW'(q[l]);
      // t = n * 2^16 / den; top part of the dividend seeds the remainder
      prep_rem[l]       = {1'b0, n[QW-1:2]};
      prep_lowq[l]      = {n[1:0], {seg_clip_pkg::T_FRAC{1'b0}}};
      prep_side.ovf[l]  = {1'b0, n[QW-1:2]} >= prep_den[l];
    end
  end

  // divider chain, stage 0 is the prep register
  logic                  c_valid [0:NS];
  logic                  c_ready [0:NS];
  logic [SW-1:0]         c_side  [0:NS];
  logic [NL-1:0][CB:0]   c_den   [0:NS];
  logic [NL-1:0][CB:0]   c_rem   [0:NS];
  logic [NL-1:0][TB-1:0] c_lowq  [0:NS];

  assign seg_in.ready = !c_valid[0] || c_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (seg_in.ready) begin
      c_valid[0] <= seg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_in.ready) begin
      c_side[0] <= prep_side;
      c_den[0]  <= prep_den;
      c_rem[0]  <= prep_rem;
      c_lowq[0] <= prep_lowq;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cell
    seg_clip_cell #(.CB(CB), .SW(SW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .side_in   (c_side[k]),
      .den_in    (c_den[k]),
      .rem_in    (c_rem[k]),
      .lowq_in   (c_lowq[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .side_out  (c_side[k+1]),
      .den_out   (c_den[k+1]),
      .rem_out   (c_rem[k+1]),
      .lowq_out  (c_lowq[k+1])
    );
  end

  // fold the left, right, top and bottom edges into the enter/leave parameters
  side_t                div_side;
  logic                 fold_ok;
  logic signed [TB:0]   fold_t0;
  logic signed [TB:0]   fold_t1;

  assign div_side = c_side[NS];

  always_comb begin
    logic signed [TB:0] tv;
    fold_ok = 1'b1;
    fold_t0 = '0;
    fold_t1 = $signed({1'b0, seg_clip_pkg::T_ONE});
    for (int l = 0; l < NL; l++) begin
      // t clamped to [-1, 65537] keeps every compare outcome
      if (div_side.qz[l]) begin
        tv = '0;
      end else if (div_side.tneg[l]) begin
        tv = '1;
      end else if (div_side.ovf[l] || c_lowq[NS][l] > seg_clip_pkg::T_SAT) begin
        tv = $signed({1'b0, seg_clip_pkg::T_SAT});
      end else begin
        tv = $signed({1'b0, c_lowq[NS][l]});
      end
      if (fold_ok) begin
        if (div_side.pz[l]) begin
          if (div_side.qneg[l]) fold_ok = 1'b0;
        end else if (div_side.pneg[l]) begin
          if (tv > fold_t1) fold_ok = 1'b0;
          else if (tv > fold_t0) fold_t0 = tv;
        end else begin
          if (tv < fold_t0) fold_ok = 1'b0;
          else if (tv < fold_t1) fold_t1 = tv;
        end
      end
    end
  end

  logic                 f1_valid;
  logic                 f1_ready;
  logic                 f1_ok;
  logic [TB-1:0]        f1_t0;
  logic [TB-1:0]        f1_t1;
  side_t                f1_side;

  logic                 f2_valid;
  logic                 f2_ready;
  logic                 f2_ok;
  logic signed [PW-1:0] f2_prod [NL];
  side_t                f2_side;

  assign c_ready[NS] = !f1_valid || f1_ready;
  assign f1_ready    = !f2_valid || f2_ready;
  assign f2_ready    = !seg_out.valid || seg_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid      <= 1'b0;
      f2_valid      <= 1'b0;
      seg_out.valid <= 1'b0;
    end else begin
      if (c_ready[NS]) f1_valid <= c_valid[NS];
      if (f1_ready) f2_valid <= f1_valid;
      if (f2_ready) seg_out.valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready[NS]) begin
      f1_ok   <= fold_ok;
      f1_t0   <= fold_t0[TB-1:0];
      f1_t1   <= fold_t1[TB-1:0];
      f1_side <= div_side;
    end
  end

  // d * t for both endpoints
  always_ff @(posedge clk) begin
    if (f1_ready) begin
      f2_ok      <= f1_ok;
      f2_side    <= f1_side;
      f2_prod[0] <= PW'(f1_side.dx) * $signed(PW'({1'b0, f1_t0}));
      f2_prod[1] <= PW'(f1_side.dy) * $signed(PW'({1'b0, f1_t0}));
      f2_prod[2] <= PW'(f1_side.dx) * $signed(PW'({1'b0, f1_t1}));
      f2_prod[3] <= PW'(f1_side.dy) * $signed(PW'({1'b0, f1_t1}));
    end
  end

  // arithmetic shift floors the scaled offset
  logic signed [PW-1:0] off [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      off[l] = f2_prod[l] >>> seg_clip_pkg::T_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_ready) begin
      seg_out.visible <= f2_ok;
      if (f2_ok) begin
        seg_out.clipped_start_x <= f2_side.x0 + off[0][CB-1:0];
        seg_out.clipped_start_y <= f2_side.y0 + off[1][CB-1:0];
        seg_out.clipped_end_x   <= f2_side.x0 + off[2][CB-1:0];
        seg_out.clipped_end_y   <= f2_side.y0 + off[3][CB-1:0];
      end else begin
        seg_out.clipped_start_x <= f2_side.x0;
        seg_out.clipped_start_y <= f2_side.y0;
        seg_out.clipped_end_x   <= f2_side.x1;
        seg_out.clipped_end_y   <= f2_side.y1;
      end
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !seg_out.valid && !c_valid[0])
    else $error("pipeline not empty after reset");
  a_t_order: assert property (@(posedge clk) disable iff (rst)
    f1_valid && f1_ok |-> f1_t0 <= f1_t1)
    else $error("enter parameter beyond leave parameter on visible segment");
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    f1_valid && f1_ok |-> f1_t1 <= seg_clip_pkg::T_ONE)
    else $error("leave parameter above one");
`endif

endmodule

@@ src/seg_clip_cell.sv @@
// ----------------------------------------------------------------------------
// seg_clip_cell
// One restoring division step for each rectangle side, plus a pipeline register.
// ----------------------------------------------------------------------------
module seg_clip_cell #(
  parameter int CB = 24,
  parameter int SW = 8
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [SW-1:0]                                  side_in,
  input  logic [seg_clip_pkg::NUM_LANES-1:0][CB:0]       den_in,
  input  logic [seg_clip_pkg::NUM_LANES-1:0][CB:0]       rem_in,
  input  logic [seg_clip_pkg::NUM_LANES-1:0][seg_clip_pkg::T_BITS-1:0] lowq_in,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [SW-1:0]                                  side_out,
  output logic [seg_clip_pkg::NUM_LANES-1:0][CB:0]       den_out,
  output logic [seg_clip_pkg::NUM_LANES-1:0][CB:0]       rem_out,
  output logic [seg_clip_pkg::NUM_LANES-1:0][seg_clip_pkg::T_BITS-1:0] lowq_out
);

  logic [seg_clip_pkg::NUM_LANES-1:0][CB:0]                 rem_next;
  logic [seg_clip_pkg::NUM_LANES-1:0][seg_clip_pkg::T_BITS-1:0] lowq_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic [CB+1:0] sh;
    logic [CB+1:0] diff;
    logic          ge;
    for (int l = 0; l < seg_clip_pkg::NUM_LANES; l++) begin
      sh   = {rem_in[l], lowq_in[l][seg_clip_pkg::T_BITS-1]};
      ge   = sh >= {1'b0, den_in[l]};
      diff = sh - {1'b0, den_in[l]};
      rem_next[l]  = ge ? diff[CB:0] : sh[CB:0];
      lowq_next[l] = {lowq_in[l][seg_clip_pkg::T_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      side_out <= side_in;
      den_out  <= den_in;
      rem_out  <= rem_next;
      lowq_out <= lowq_next;
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment rectangle clipper.
// ----------------------------------------------------------------------------
// Segments go in on seg_in; every accepted segment queues an expected clip
// result, typed in or from a bench-side Liang-Barsky predictor. Results on seg_out are
// checked in order. A directed table runs first: its reset, extreme and
// rejection rows carry a typed-in result and the rest use the predictor.
// Random phases follow. Each phase uses a new rectangle, the extremes among
// them, and one of four idle patterns on the sender and receiver sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam longint CMAX = 8388607;
  localparam longint CMIN = -8388608;
  localparam longint T_UNIT = 65536;
  localparam int WATCHDOG = 5000;

  typedef struct {
    logic signed [CB-1:0] sx, sy, ex, ey;
  } seg_t;

  typedef struct {
    logic                 vis;
    logic signed [CB-1:0] sx, sy, ex, ey;
  } clip_t;

  typedef struct {
    seg_t  seg;
    bit    typed;
    clip_t res;
  } row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 0;
  logic rst;

  seg_clip_in_if  #(CB) in_if();
  seg_clip_out_if #(CB) out_if();
  seg_clip_cfg_if #(CB) cfg_if();

  segment_rect_clipper #(.COORD_BITS(CB)) u_dut (
    .clk(clk), .rst(rst), .seg_in(in_if), .seg_out(out_if), .cfg(cfg_if)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // rectangle copy held by the bench
  longint rect_left, rect_top, rect_w, rect_h;
  clip_t clip_q[$];
  idle_mode_t mode = IDLE_NONE;
  int fail_cnt = 0;
  int quiet_cycles = 0;

  function automatic longint fdiv(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic clip_t clip_predict(seg_t s);
    longint x0, y0, x1, y1, dx, dy, t0, t1, num, den, t;
    longint p[4], q[4];
    bit ok;
    clip_t r;
    x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
    dx = x1 - x0; dy = y1 - y0;
    t0 = 0; t1 = T_UNIT; ok = 1;
    p[0] = -dx; q[0] = x0 - rect_left;
    p[1] = dx;  q[1] = rect_left + rect_w - x0;
    p[2] = -dy; q[2] = y0 - rect_top;
    p[3] = dy;  q[3] = rect_top + rect_h - y0;
    for (int i = 0; i < 4 && ok; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) ok = 0;
      end else begin
        num = q[i] * T_UNIT;
        den = p[i];
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        t = fdiv(num, den);
        if (p[i] < 0) begin
          if (t > t1) ok = 0;
          else if (t > t0) t0 = t;
        end else begin
          if (t < t0) ok = 0;
          else if (t < t1) t1 = t;
        end
      end
    end
    if (ok) begin
      r.vis = 1;
      r.sx = CB'(x0 + fdiv(dx * t0, T_UNIT));
      r.sy = CB'(y0 + fdiv(dy * t0, T_UNIT));
      r.ex = CB'(x0 + fdiv(dx * t1, T_UNIT));
      r.ey = CB'(y0 + fdiv(dy * t1, T_UNIT));
    end else begin
      r.vis = 0;
      r.sx = s.sx; r.sy = s.sy; r.ex = s.ex; r.ey = s.ey;
    end
    return r;
  endfunction

  function automatic bit send_gap();
    if (mode == IDLE_SEND) return $urandom_range(0, 99) < 69;
    if (mode == IDLE_BOTH) return $urandom_range(0, 99) < 11;
    return 0;
  endfunction

  function automatic bit recv_stall();
    if (mode == IDLE_RECV) return $urandom_range(0, 99) < 69;
    if (mode == IDLE_BOTH) return $urandom_range(0, 99) < 11;
    return 0;
  endfunction

  function automatic logic signed [CB-1:0] sat(longint v);
    if (v > CMAX) return CB'(CMAX);
    if (v < CMIN) return CB'(CMIN);
    return CB'(v);
  endfunction

  // coordinate around a span, reaching half the span plus 16 past both sides
  function automatic logic signed [CB-1:0] near(longint lo, longint span);
    longint m;
    m = span / 2 + 16;
    return sat(lo - m + longint'($urandom_range(0, 32'(span + 2 * m))));
  endfunction

  function automatic seg_t rand_seg();
    seg_t s;
    int kind;
    kind = $urandom_range(0, 9);
    s.sx = near(rect_left, rect_w); s.sy = near(rect_top, rect_h);
    s.ex = near(rect_left, rect_w); s.ey = near(rect_top, rect_h);
    case (kind)
      0: begin
        s.sx = CB'($urandom); s.sy = CB'($urandom);
        s.ex = CB'($urandom); s.ey = CB'($urandom);
      end
      1: begin
        s.ex = s.sx; s.ey = s.sy;
      end
      2: s.ex = s.sx;
      3: s.ey = s.sy;
      4: begin
        s.sx = CB'($urandom); s.ey = CB'($urandom);
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic cfg_write(seg_clip_pkg::reg_idx_t idx, logic [CB-1:0] data);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      seg_clip_pkg::REG_LEFT:   rect_left = longint'(signed'(data));
      seg_clip_pkg::REG_TOP:    rect_top  = longint'(signed'(data));
      seg_clip_pkg::REG_WIDTH:  rect_w    = longint'(data[CB-2:0]);
      seg_clip_pkg::REG_HEIGHT: rect_h    = longint'(data[CB-2:0]);
      default: ;
    endcase
  endtask

  task automatic set_rect(longint l, longint t, longint w, longint h);
    cfg_write(seg_clip_pkg::REG_LEFT, CB'(l));
    cfg_write(seg_clip_pkg::REG_TOP, CB'(t));
    cfg_write(seg_clip_pkg::REG_WIDTH, CB'(w));
    cfg_write(seg_clip_pkg::REG_HEIGHT, CB'(h));
    cfg_if.valid <= 0;
  endtask

  task automatic send_seg(seg_t s, bit typed, clip_t r);
    while (send_gap()) begin
      in_if.valid <= 0;
      @(posedge clk);
    end
    in_if.valid   <= 1;
    in_if.start_x <= s.sx;
    in_if.start_y <= s.sy;
    in_if.end_x   <= s.ex;
    in_if.end_y   <= s.ey;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    clip_q.insert(clip_q.size(), typed ? r : clip_predict(s));
  endtask

  task automatic drain();
    in_if.valid <= 0;
    while (clip_q.size() != 0) @(posedge clk);
  endtask

  // result check and stall pattern on the receiver side
  always @(posedge clk) begin
    clip_t want;
    if (rst) begin
      out_if.ready <= 0;
    end else begin
      out_if.ready <= !recv_stall();
      if (out_if.valid && out_if.ready) begin
        if (clip_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result word with nothing expected", $realtime);
        end else begin
          want = clip_q.pop_front();
          if (out_if.visible !== want.vis || out_if.clipped_start_x !== want.sx ||
              out_if.clipped_start_y !== want.sy || out_if.clipped_end_x !== want.ex ||
              out_if.clipped_end_y !== want.ey) begin
            fail_cnt++;
            $display({"%0t: mismatch exp vis=%0d (%0d,%0d)-(%0d,%0d)",
                      " got vis=%0d (%0d,%0d)-(%0d,%0d)"},
                     $realtime, want.vis, want.sx, want.sy, want.ex, want.ey,
                     out_if.visible, out_if.clipped_start_x, out_if.clipped_start_y,
                     out_if.clipped_end_x, out_if.clipped_end_y);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired at %0t", $realtime);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic row_t mk(longint sx, longint sy, longint ex, longint ey);
    row_t r;
    r.seg.sx = CB'(sx); r.seg.sy = CB'(sy); r.seg.ex = CB'(ex); r.seg.ey = CB'(ey);
    r.typed = 0;
    r.res = '{0, 0, 0, 0, 0};
    return r;
  endfunction

  function automatic row_t mk_typed(longint sx, longint sy, longint ex, longint ey,
                                    bit v, longint rsx, longint rsy, longint rex,
                                    longint rey);
    row_t r;
    r = mk(sx, sy, ex, ey);
    r.typed = 1;
    r.res = '{v, CB'(rsx), CB'(rsy), CB'(rex), CB'(rey)};
    return r;
  endfunction

  initial begin
    row_t reset_rows[$];
    row_t rect_rows[$];
    longint rl, rt, rw, rh;
    rst <= 1;
    in_if.valid <= 0;
    in_if.start_x <= 0; in_if.start_y <= 0; in_if.end_x <= 0; in_if.end_y <= 0;
    cfg_if.valid <= 0; cfg_if.index <= 0; cfg_if.data <= 0;
    rect_left = 0; rect_top = 0; rect_w = 0; rect_h = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset the rectangle is the single point at the origin
    reset_rows = {mk_typed(0, 0, 0, 0, 1, 0, 0, 0, 0),
                  mk_typed(256, 0, 256, 512, 0, 256, 0, 256, 512),
                  mk_typed(CMIN, CMIN, CMIN, CMIN, 0, CMIN, CMIN, CMIN, CMIN),
                  mk_typed(CMAX, CMAX, CMAX, CMAX, 0, CMAX, CMAX, CMAX, CMAX),
                  mk_typed(-512, 0, 512, 0, 1, 0, 0, 0, 0),
                  mk(CMIN, CMIN, CMAX, CMAX)};
    foreach (reset_rows[i]) send_seg(reset_rows[i].seg, reset_rows[i].typed, reset_rows[i].res);
    drain();

    // unknown indexes are dropped, width bit above its field is dropped
    cfg_write(seg_clip_pkg::reg_idx_t'(4), 24'h123456);
    cfg_write(seg_clip_pkg::reg_idx_t'(255), 24'hFFFFFF);
    cfg_write(seg_clip_pkg::REG_LEFT, CB'(-2560));
    cfg_write(seg_clip_pkg::REG_TOP, CB'(-1280));
    cfg_write(seg_clip_pkg::REG_WIDTH, 24'h800000 | 24'd5120);
    cfg_write(seg_clip_pkg::REG_HEIGHT, 24'd2560);
    cfg_if.valid <= 0;

    rect_rows = {mk(-256, -256, 256, 256),
                 mk(-5000, 0, 0, 0),
                 mk(-6000, -3000, 6000, 3000),
                 mk(6000, 3000, -6000, -3000),
                 mk(0, -4000, 0, 4000),
                 mk_typed(-3000, -2000, 3000, -2000, 0, -3000, -2000, 3000, -2000),
                 mk_typed(3000, 0, 3000, 500, 0, 3000, 0, 3000, 500),
                 mk(100, 100, 100, 100),
                 mk(-2560, -1280, -2560, -1280),
                 mk(2560, 1280, 2560, 1280),
                 mk(-2560, -2000, 2560, 2000),
                 mk(-6000, 3000, 0, -6000),
                 mk(CMIN, CMAX, CMAX, CMIN),
                 mk(CMAX, 0, CMIN, 0),
                 mk(0, CMIN, 1, CMAX)};
    foreach (rect_rows[i]) send_seg(rect_rows[i].seg, rect_rows[i].typed, rect_rows[i].res);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin rl = CMIN; rt = CMIN; rw = CMAX; rh = CMAX; end
        1: begin rl = 0; rt = 0; rw = 0; rh = 0; end
        2: begin rl = CMAX; rt = CMAX; rw = CMAX; rh = CMAX; end
        3: begin rl = -1000; rt = 2000; rw = 0; rh = 4000; end
        default: begin
          rl = longint'($urandom_range(0, 2000000)) - 1000000;
          rt = longint'($urandom_range(0, 2000000)) - 1000000;
          rw = $urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom_range(0, 8388607);
          rh = $urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom_range(0, 8388607);
        end
      endcase
      set_rect(rl, rt, rw, rh);
      mode = idle_mode_t'(ph % 4);
      repeat (100) send_seg(rand_seg(), 0, '{0, 0, 0, 0, 0});
      // sender holds off until every result is back
      drain();
    end

    mode = IDLE_NONE;
    drain();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && clip_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/seg_clip_pkg.sv
src/seg_clip_if.sv
src/seg_clip_cell.sv
src/segment_rect_clipper.sv
tb/tb.sv
